// ===== sv/line_follower_route_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Line follower route sequencer: assertion macros
// Shared macros for the concurrent checks on the sequencer's ports.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_ROUTE_SEQUENCER_DEFINES_SVH
`define LINE_FOLLOWER_ROUTE_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Line follower route sequencer package
// Route phases, drive patterns and register indexes shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package lfrs_pkg;

   // Route phases: three following legs, two phases for each spin turn, stop.
   typedef enum logic [2:0] {
      PH_LEG1 = 3'd0,
      PH_RA   = 3'd1,
      PH_RB   = 3'd2,
      PH_LEG2 = 3'd3,
      PH_LA   = 3'd4,
      PH_LB   = 3'd5,
      PH_LEG3 = 3'd6,
      PH_DONE = 3'd7
   } phase_type;

   // H-bridge drive patterns.
   localparam logic [3:0] PAT_STOP  = 4'd0;
   localparam logic [3:0] PAT_FWD   = 4'd5;
   localparam logic [3:0] PAT_RIGHT = 4'd6;
   localparam logic [3:0] PAT_LEFT  = 4'd9;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_BITS = 3;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LEG1  = 3'd0,
      CSR_LEG2  = 3'd1,
      CSR_LEG3  = 3'd2,
      CSR_FWD   = 3'd3,
      CSR_STEER = 3'd4,
      CSR_TURN  = 3'd5
   } csr_index_type;

   // Phase evaluations that one sample can need: a leg may end, a turn
   // phase may pass, and the next phase still sees the same sample.
   localparam int unsigned PASSES = 4;

   // Sensor sample; each bit is 0 when that sensor sees the line.
   typedef struct packed {
      logic d;
      logic c;
      logic b;
      logic a;
   } sensor_type;

   localparam int unsigned SENSOR_BITS = $bits(sensor_type);

endpackage

`default_nettype wire

// ===== sv/line_follower_route_sequencer.sv =====
// ----------------------------------------------------------------------------
// Line follower route sequencer
// Drives a fixed three-leg route from a stream of four-sensor line samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one sensor sample per transfer; rsp_ returns exactly one
//   motor command per sample, in order: drive pattern, both PWM duties, the
//   junction count of the current leg and the route-done flag.
//   csr_ writes the leg junction targets and speeds; it is always ready and
//   should only be written while no sample is in flight.
//   A req_ sample passes through the input register and then the
//   sequencing stage, whose state registers are the result. Throughput is
//   one sample per cycle while the receiver takes results, set by the
//   single update of the route state registers in the sequencing stage.
//   When the receiver stalls, the result holds and one further sample is
//   taken into the input register before req_tready drops.
//   Reset returns the route to the first leg with the motors stopped, both
//   duties and the junction count at zero, and loads the default targets
//   (2, 1, 1) and speeds (512, 612, 250).
// ----------------------------------------------------------------------------
`default_nettype none

module line_follower_route_sequencer
   import lfrs_pkg::*;
#(
   parameter int unsigned DUTY_BITS  = 10,
   parameter int unsigned COUNT_BITS = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // sensor_a, sensor_b, sensor_c, sensor_d from bit 0 up, zero padded
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,
   // drive_pattern, left_duty, right_duty, junction_count, route_done
   // from bit 0 up, zero padded
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [((5+2*DUTY_BITS+COUNT_BITS+7)/8)*8-1:0] rsp_tdata,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [DUTY_BITS-1:0]      csr_wdata
);

   localparam int unsigned FIELD_BITS = 5 + 2*DUTY_BITS + COUNT_BITS;
   localparam int unsigned RSP_BITS   = ((FIELD_BITS + 7) / 8) * 8;

   logic [COUNT_BITS-1:0] leg1_target, leg2_target, leg3_target;
   logic [DUTY_BITS-1:0]  forward_speed, steer_speed, turn_speed;
   logic                  advance;
   logic                  sample_valid;
   sensor_type            sample;
   sensor_type            req_sample;
   logic [3:0]            drive_pattern;
   logic [DUTY_BITS-1:0]  left_duty, right_duty;
   logic [COUNT_BITS-1:0] junction_count;
   logic                  route_done;

   assign csr_ready  = 1'b1;
   assign req_sample = sensor_type'(req_tdata[SENSOR_BITS-1:0]);

   lfrs_csr #(
      .DUTY_BITS  (DUTY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .leg1_target   (leg1_target),
      .leg2_target   (leg2_target),
      .leg3_target   (leg3_target),
      .forward_speed (forward_speed),
      .steer_speed   (steer_speed),
      .turn_speed    (turn_speed)
   );

   lfrs_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_sample   (req_sample),
      .advance      (advance),
      .sample_valid (sample_valid),
      .sample       (sample)
   );

   lfrs_core #(
      .DUTY_BITS  (DUTY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .leg1_target    (leg1_target),
      .leg2_target    (leg2_target),
      .leg3_target    (leg3_target),
      .forward_speed  (forward_speed),
      .steer_speed    (steer_speed),
      .turn_speed     (turn_speed),
      .sample_valid   (sample_valid),
      .sample         (sample),
      .advance        (advance),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .drive_pattern  (drive_pattern),
      .left_duty      (left_duty),
      .right_duty     (right_duty),
      .junction_count (junction_count),
      .route_done     (route_done)
   );

   // Pack the result fields, lowest field first.
   assign rsp_tdata = RSP_BITS'({route_done, junction_count, right_duty,
                                 left_duty, drive_pattern});

endmodule

`default_nettype wire

// ===== sv/lfrs_csr.sv =====
// ----------------------------------------------------------------------------
// Line follower route sequencer: configuration registers
// Leg junction targets and the three wheel speeds, written over the CSR port.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrs_csr
   import lfrs_pkg::*;
#(
   parameter int unsigned DUTY_BITS  = 10,
   parameter int unsigned COUNT_BITS = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [DUTY_BITS-1:0]      csr_wdata,
   output logic [COUNT_BITS-1:0]          leg1_target,
   output logic [COUNT_BITS-1:0]          leg2_target,
   output logic [COUNT_BITS-1:0]          leg3_target,
   output logic [DUTY_BITS-1:0]           forward_speed,
   output logic [DUTY_BITS-1:0]           steer_speed,
   output logic [DUTY_BITS-1:0]           turn_speed
);

   logic [COUNT_BITS-1:0] leg1_ff, leg1_in;
   logic [COUNT_BITS-1:0] leg2_ff, leg2_in;
   logic [COUNT_BITS-1:0] leg3_ff, leg3_in;
   logic [DUTY_BITS-1:0]  fwd_ff, fwd_in;
   logic [DUTY_BITS-1:0]  steer_ff, steer_in;
   logic [DUTY_BITS-1:0]  turn_ff, turn_in;

   // Write decode; indexes beyond the register list are dropped.
   always_comb begin
      leg1_in  = leg1_ff;
      leg2_in  = leg2_ff;
      leg3_in  = leg3_ff;
      fwd_in   = fwd_ff;
      steer_in = steer_ff;
      turn_in  = turn_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEG1:  leg1_in  = csr_wdata[COUNT_BITS-1:0];
            CSR_LEG2:  leg2_in  = csr_wdata[COUNT_BITS-1:0];
            CSR_LEG3:  leg3_in  = csr_wdata[COUNT_BITS-1:0];
            CSR_FWD:   fwd_in   = csr_wdata;
            CSR_STEER: steer_in = csr_wdata;
            CSR_TURN:  turn_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Register bank with its documented reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         leg1_ff  <= COUNT_BITS'(2);
         leg2_ff  <= COUNT_BITS'(1);
         leg3_ff  <= COUNT_BITS'(1);
         fwd_ff   <= DUTY_BITS'(512);
         steer_ff <= DUTY_BITS'(612);
         turn_ff  <= DUTY_BITS'(250);
      end else begin
         leg1_ff  <= leg1_in;
         leg2_ff  <= leg2_in;
         leg3_ff  <= leg3_in;
         fwd_ff   <= fwd_in;
         steer_ff <= steer_in;
         turn_ff  <= turn_in;
      end
   end

   assign leg1_target   = leg1_ff;
   assign leg2_target   = leg2_ff;
   assign leg3_target   = leg3_ff;
   assign forward_speed = fwd_ff;
   assign steer_speed   = steer_ff;
   assign turn_speed    = turn_ff;

endmodule

`default_nettype wire

// ===== sv/lfrs_in_reg.sv =====
// ----------------------------------------------------------------------------
// Line follower route sequencer: input register
// Holds one accepted sensor sample until the sequencing stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrs_in_reg
   import lfrs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire sensor_type req_sample,
   input  wire logic       advance,
   output logic            sample_valid,
   output sensor_type      sample
);

   logic       valid_ff, valid_in;
   sensor_type sample_ff, sample_in;
   logic       req_accept;

   // Room exists when the register is empty or its sample leaves this cycle.
   assign req_tready = !valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      valid_in  = valid_ff;
      sample_in = sample_ff;
      if (req_accept) begin
         valid_in  = 1'b1;
         sample_in = req_sample;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign sample_valid = valid_ff;
   assign sample       = sample_ff;

endmodule

`default_nettype wire

// ===== sv/lfrs_core.sv =====
// ----------------------------------------------------------------------------
// Line follower route sequencer: sequencing stage
// Applies one sample to the route state; the state registers form the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrs_core
   import lfrs_pkg::*;
#(
   parameter int unsigned DUTY_BITS  = 10,
   parameter int unsigned COUNT_BITS = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [COUNT_BITS-1:0] leg1_target,
   input  wire logic [COUNT_BITS-1:0] leg2_target,
   input  wire logic [COUNT_BITS-1:0] leg3_target,
   input  wire logic [DUTY_BITS-1:0]  forward_speed,
   input  wire logic [DUTY_BITS-1:0]  steer_speed,
   input  wire logic [DUTY_BITS-1:0]  turn_speed,
   input  wire logic                  sample_valid,
   input  wire sensor_type            sample,
   output logic                       advance,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [3:0]                 drive_pattern,
   output logic [DUTY_BITS-1:0]       left_duty,
   output logic [DUTY_BITS-1:0]       right_duty,
   output logic [COUNT_BITS-1:0]      junction_count,
   output logic                       route_done
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   phase_type             phase_ff, phase_in;
   logic                  onj_ff, onj_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [3:0]            pat_ff, pat_in;
   logic [DUTY_BITS-1:0]  ld_ff, ld_in;
   logic [DUTY_BITS-1:0]  rd_ff, rd_in;
   logic                  valid_ff, valid_in;
   logic                  fire;
   logic                  see_a, see_b, see_c, see_d, see_all;

   // The result stage drains when empty or when its transfer completes.
   assign advance = !valid_ff || rsp_ready;
   assign fire    = sample_valid && advance;

   // True where the sensor sees the line.
   assign see_a   = !sample.a;
   assign see_b   = !sample.b;
   assign see_c   = !sample.c;
   assign see_d   = !sample.d;
   assign see_all = see_a && see_b && see_c && see_d;

   // Next route state: a phase that ends hands the same sample on to the
   // next phase, so a few phase evaluations are chained per sample.
   always_comb begin
      logic                  fin;
      logic [COUNT_BITS-1:0] target;
      phase_type             next_ph;
      phase_in = phase_ff;
      onj_in   = onj_ff;
      cnt_in   = cnt_ff;
      pat_in   = pat_ff;
      ld_in    = ld_ff;
      rd_in    = rd_ff;
      fin      = !fire;
      target   = leg3_target;
      next_ph  = PH_DONE;
      for (int i = 0; i < PASSES; i++) begin
         if (!fin) begin
            target  = leg3_target;
            next_ph = PH_DONE;
            if (phase_in == PH_LEG1) begin
               target  = leg1_target;
               next_ph = PH_RA;
            end else if (phase_in == PH_LEG2) begin
               target  = leg2_target;
               next_ph = PH_LA;
            end
            unique case (phase_in)
               PH_LEG1, PH_LEG2, PH_LEG3: begin
                  if (onj_in && see_all) begin
                     // Still crossing the junction: hold the forward command.
                     fin = 1'b1;
                  end else begin
                     onj_in = 1'b0;
                     if (cnt_in >= target) begin
                        // Leg complete: start the turn or stop.
                        phase_in = next_ph;
                        if (next_ph == PH_RA) begin
                           pat_in = PAT_RIGHT;
                           ld_in  = turn_speed;
                           rd_in  = turn_speed;
                        end else if (next_ph == PH_LA) begin
                           pat_in = PAT_LEFT;
                           ld_in  = turn_speed;
                           rd_in  = turn_speed;
                        end else begin
                           pat_in = PAT_STOP;
                        end
                     end else begin
                        fin = 1'b1;
                        if (see_all) begin
                           pat_in = PAT_FWD;
                           ld_in  = forward_speed;
                           rd_in  = forward_speed;
                           if (cnt_in != COUNT_MAX) begin
                              cnt_in = cnt_in + COUNT_BITS'(1);
                           end
                           onj_in = 1'b1;
                        end else if (see_b && see_c) begin
                           pat_in = PAT_FWD;
                           ld_in  = forward_speed;
                           rd_in  = forward_speed;
                        end else if (!see_b && see_c) begin
                           pat_in = PAT_FWD;
                           ld_in  = steer_speed;
                           rd_in  = '0;
                        end else if (see_b && !see_c) begin
                           pat_in = PAT_FWD;
                           ld_in  = '0;
                           rd_in  = steer_speed;
                        end
                     end
                  end
               end
               PH_RA: begin
                  if (see_b && !see_c) phase_in = PH_RB;
                  else fin = 1'b1;
               end
               PH_RB: begin
                  if (see_b && see_c) begin
                     phase_in = PH_LEG2;
                     cnt_in   = '0;
                     onj_in   = 1'b0;
                  end else begin
                     fin = 1'b1;
                  end
               end
               PH_LA: begin
                  if (!see_b && see_c) phase_in = PH_LB;
                  else fin = 1'b1;
               end
               PH_LB: begin
                  if (see_b && see_c) begin
                     phase_in = PH_LEG3;
                     cnt_in   = '0;
                     onj_in   = 1'b0;
                  end else begin
                     fin = 1'b1;
                  end
               end
               PH_DONE: begin
                  pat_in = PAT_STOP;
                  fin    = 1'b1;
               end
               default: begin
                  phase_in = PH_DONE;
                  pat_in   = PAT_STOP;
                  fin      = 1'b1;
               end
            endcase
         end
      end
   end

   // Result valid flag.
   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEG1;
         onj_ff   <= 1'b0;
         cnt_ff   <= '0;
         pat_ff   <= PAT_STOP;
         ld_ff    <= '0;
         rd_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         onj_ff   <= onj_in;
         cnt_ff   <= cnt_in;
         pat_ff   <= pat_in;
         ld_ff    <= ld_in;
         rd_ff    <= rd_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign drive_pattern  = pat_ff;
   assign left_duty      = ld_ff;
   assign right_duty     = rd_ff;
   assign junction_count = cnt_ff;
   assign route_done     = (phase_ff == PH_DONE);

endmodule

`default_nettype wire

// ===== sv/lfrs_checker.sv =====
// ----------------------------------------------------------------------------
// Line follower route sequencer: port checker
// Concurrent checks on the sequencer's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_follower_route_sequencer_defines.svh"

module lfrs_checker
   import lfrs_pkg::*;
#(
   parameter int unsigned DUTY_BITS  = 10,
   parameter int unsigned COUNT_BITS = 4
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [((5+2*DUTY_BITS+COUNT_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int unsigned DONE_BIT = 4 + 2*DUTY_BITS + COUNT_BITS;

   logic       shown_done;
   logic [3:0] shown_pattern;

   assign shown_done    = rsp_tdata[DONE_BIT];
   assign shown_pattern = rsp_tdata[3:0];

   // A stalled result keeps its value until the transfer.
   `LFRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // A finished route always shows stopped motors.
   `LFRS_ASSERT_SAME(a_done_stopped, clock, reset, rsp_tvalid && shown_done, shown_pattern == PAT_STOP, "route done with motors running")

   // No result is offered straight after reset.
   `LFRS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")

   // An empty block always has room for a sample.
   `LFRS_ASSERT_NEXT(a_ready_idle, clock, reset, !req_tvalid && !rsp_tvalid && !$past(req_tvalid), req_tready, "idle block not ready")

endmodule

bind line_follower_route_sequencer lfrs_checker #(
   .DUTY_BITS  (DUTY_BITS),
   .COUNT_BITS (COUNT_BITS)
) u_checker (.*);

`default_nettype wire
